// ===== src/thkm_pkg.sv =====
// Package for the tap-hold key mask unit: slot count, widths, key codes,
// register map and the control bundle passed to the slot timers.
// No dependencies.
package thkm_pkg;

    localparam int SLOT_COUNT = 12;
    localparam int CNT_W      = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CNT_W-1:0] TAP_FRAMES_RESET = 6'd6;

    // Register indexes (register i sits at byte address 4*i).
    localparam logic REG_TAP_FRAMES = 1'b0;

    // Input item kinds.
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Key characters, in slot order A,B,X,Y,START,UP,DOWN,LEFT,RIGHT,Z,L,R.
    localparam logic [7:0] KEY_A     = 8'h61;  // 'a'
    localparam logic [7:0] KEY_B     = 8'h62;  // 'b'
    localparam logic [7:0] KEY_X     = 8'h78;  // 'x'
    localparam logic [7:0] KEY_Y     = 8'h79;  // 'y'
    localparam logic [7:0] KEY_START = 8'h73;  // 's'
    localparam logic [7:0] KEY_UP    = 8'h75;  // 'u'
    localparam logic [7:0] KEY_DOWN  = 8'h64;  // 'd'
    localparam logic [7:0] KEY_LEFT  = 8'h6C;  // 'l'
    localparam logic [7:0] KEY_RIGHT = 8'h72;  // 'r'
    localparam logic [7:0] KEY_Z     = 8'h7A;  // 'z'
    localparam logic [7:0] KEY_L     = 8'h4C;  // 'L'
    localparam logic [7:0] KEY_R     = 8'h52;  // 'R'

    typedef logic [SLOT_COUNT-1:0] slot_mask_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // One step for the slot timers: a key reload or a frame tick.
    typedef struct packed {
        logic       load;
        logic       tick;
        slot_mask_t load_slot;
    } thkm_ctrl_t;

endpackage

// ===== src/thkm_key_decode.sv =====
// Key byte decoder: maps a received character onto a one-hot slot mask.
// Unknown characters give an empty mask. Depends on thkm_pkg.
module thkm_key_decode
(
    input  logic [7:0]           key_byte,
    output thkm_pkg::slot_mask_t slot_onehot
);

    always_comb
    begin
        slot_onehot = '0;
        case (key_byte)
            thkm_pkg::KEY_A:     slot_onehot[0]  = 1'b1;
            thkm_pkg::KEY_B:     slot_onehot[1]  = 1'b1;
            thkm_pkg::KEY_X:     slot_onehot[2]  = 1'b1;
            thkm_pkg::KEY_Y:     slot_onehot[3]  = 1'b1;
            thkm_pkg::KEY_START: slot_onehot[4]  = 1'b1;
            thkm_pkg::KEY_UP:    slot_onehot[5]  = 1'b1;
            thkm_pkg::KEY_DOWN:  slot_onehot[6]  = 1'b1;
            thkm_pkg::KEY_LEFT:  slot_onehot[7]  = 1'b1;
            thkm_pkg::KEY_RIGHT: slot_onehot[8]  = 1'b1;
            thkm_pkg::KEY_Z:     slot_onehot[9]  = 1'b1;
            thkm_pkg::KEY_L:     slot_onehot[10] = 1'b1;
            thkm_pkg::KEY_R:     slot_onehot[11] = 1'b1;
            default:             slot_onehot     = '0;
        endcase
    end

endmodule

// ===== src/thkm_slot_timers.sv =====
// Twelve saturating countdown timers plus the previous-held register.
// Produces the held and newly pressed masks for a tick. Depends on thkm_pkg.
module thkm_slot_timers
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  thkm_pkg::thkm_ctrl_t ctrl,
    input  thkm_pkg::cnt_t       tap_frames,
    output thkm_pkg::slot_mask_t held_next,
    output thkm_pkg::slot_mask_t pressed_next
);

    thkm_pkg::cnt_t       cnt_reg [thkm_pkg::SLOT_COUNT];
    thkm_pkg::cnt_t       cnt_dec [thkm_pkg::SLOT_COUNT];
    thkm_pkg::slot_mask_t prev_held_reg;

    always_comb
    begin
        for (int i = 0; i < thkm_pkg::SLOT_COUNT; i++)
        begin
            cnt_dec[i]   = (cnt_reg[i] == '0) ? '0 : cnt_reg[i] - 1'b1;
            held_next[i] = (cnt_dec[i] != '0);
        end
        pressed_next = held_next & ~prev_held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < thkm_pkg::SLOT_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
            prev_held_reg <= '0;
        end
        else if (ctrl.tick)
        begin
            for (int i = 0; i < thkm_pkg::SLOT_COUNT; i++)
            begin
                cnt_reg[i] <= cnt_dec[i];
            end
            prev_held_reg <= held_next;
        end
        else if (ctrl.load)
        begin
            for (int i = 0; i < thkm_pkg::SLOT_COUNT; i++)
            begin
                if (ctrl.load_slot[i])
                begin
                    cnt_reg[i] <= tap_frames;
                end
            end
        end
    end

endmodule

// ===== src/thkm_cfg_regs.sv =====
// APB-style configuration register block holding tap_frames.
// Depends on thkm_pkg.
module thkm_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [thkm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [thkm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [thkm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output thkm_pkg::cnt_t                  tap_frames
);

    thkm_pkg::cnt_t tap_frames_reg;
    logic           reg_index;
    logic           wr_en;

    // Registers are word spaced, so the index starts at address bit 2.
    assign reg_index = paddr[thkm_pkg::CFG_ADDR_W-1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready
                       && (reg_index == thkm_pkg::REG_TAP_FRAMES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_frames_reg <= thkm_pkg::TAP_FRAMES_RESET;
        end
        else if (wr_en)
        begin
            tap_frames_reg <= pwdata[thkm_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == thkm_pkg::REG_TAP_FRAMES)
        begin
            prdata = {{(thkm_pkg::CFG_DATA_W-thkm_pkg::CNT_W){1'b0}}, tap_frames_reg};
        end
    end

    assign tap_frames = tap_frames_reg;

endmodule

// ===== src/tap_hold_key_mask_unit.sv =====
// Tap-hold key mask unit: per-key retriggerable hold timers with press edges.
// Items and tick results are registered; twelve slot timers update in parallel.
// Throughput: one item per cycle; a tick waits while the result is stalled.
// Key bytes give no result; each frame tick gives one held/pressed item.
// Reset (rst_n low, asynchronous) clears all timers, the previous-held mask,
// both pipeline valid flags, and loads tap_frames with 6.
module tap_hold_key_mask_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [7:0]                      key_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [thkm_pkg::SLOT_COUNT-1:0] held_mask,
    output logic [thkm_pkg::SLOT_COUNT-1:0] pressed_mask,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [thkm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [thkm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [thkm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic                 in_valid_reg;
    logic                 mode_reg;
    logic [7:0]           key_byte_reg;
    logic                 out_valid_reg;
    thkm_pkg::slot_mask_t held_reg;
    thkm_pkg::slot_mask_t pressed_reg;

    thkm_pkg::cnt_t       tap_frames;
    thkm_pkg::slot_mask_t slot_onehot;
    thkm_pkg::slot_mask_t held_next;
    thkm_pkg::slot_mask_t pressed_next;
    thkm_pkg::thkm_ctrl_t ctrl;
    logic                 out_free;
    logic                 advance;

    thkm_cfg_regs u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .tap_frames (tap_frames)
    );

    thkm_key_decode u_decode
    (
        .key_byte    (key_byte_reg),
        .slot_onehot (slot_onehot)
    );

    // A key item always moves on; a tick item needs the result register free.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && ((mode_reg == thkm_pkg::MODE_KEY) || out_free);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        ctrl.load      = advance && (mode_reg == thkm_pkg::MODE_KEY);
        ctrl.tick      = advance && (mode_reg == thkm_pkg::MODE_TICK);
        ctrl.load_slot = slot_onehot;
    end

    thkm_slot_timers u_timers
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .tap_frames   (tap_frames),
        .held_next    (held_next),
        .pressed_next (pressed_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (ctrl.tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg     <= mode;
            key_byte_reg <= key_byte;
        end
        if (ctrl.tick)
        begin
            held_reg    <= held_next;
            pressed_reg <= pressed_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign held_mask    = held_reg;
    assign pressed_mask = pressed_reg;

endmodule

// ===== src/thkm_checker.sv =====
// Port-level checker for tap_hold_key_mask_unit, attached by a bind statement.
// Depends on thkm_pkg and the top level's port list.
module thkm_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [thkm_pkg::SLOT_COUNT-1:0] held_mask,
    input logic [thkm_pkg::SLOT_COUNT-1:0] pressed_mask,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [thkm_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [thkm_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [thkm_pkg::CFG_DATA_W-1:0] prdata
);

    // A newly pressed key must also be reported as held.
    a_pressed_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pressed_mask & ~held_mask) == '0))
        else $error("pressed_mask has a bit outside held_mask");

    // A stalled result item keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(held_mask)
                                       && $stable(pressed_mask)))
        else $error("result item changed while stalled");

    // tap_frames reads back what was last written to it.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite
         && (paddr[thkm_pkg::CFG_ADDR_W-1] == thkm_pkg::REG_TAP_FRAMES))
        |=> ((paddr[thkm_pkg::CFG_ADDR_W-1] != thkm_pkg::REG_TAP_FRAMES)
             || (prdata[thkm_pkg::CNT_W-1:0] == $past(pwdata[thkm_pkg::CNT_W-1:0]))))
        else $error("tap_frames readback mismatch");

    // Only the six countdown bits are ever read back.
    a_cfg_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[thkm_pkg::CFG_DATA_W-1:thkm_pkg::CNT_W] == '0)
        else $error("prdata upper bits not zero");

endmodule

bind tap_hold_key_mask_unit thkm_checker u_thkm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .held_mask    (held_mask),
    .pressed_mask (pressed_mask),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

// ===== test/tb_tap_hold_key_mask_unit.sv =====
// Self-checking testbench for tap_hold_key_mask_unit: key bytes and frame ticks
// are driven with random idling, and every tick's masks are checked against a
// local model of the hold timers. Depends on thkm_pkg and the unit's RTL.
module tb_tap_hold_key_mask_unit;

    import thkm_pkg::*;

    typedef struct {
        logic       kind;
        logic [7:0] code;
    } key_event_t;

    typedef struct {
        slot_mask_t held;
        slot_mask_t pressed;
    } hold_masks_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  mode      = MODE_KEY;
    logic [7:0]            key_byte  = 8'h00;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    slot_mask_t            held_mask;
    slot_mask_t            pressed_mask;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Local copy of the block's state.
    cnt_t       countdown [SLOT_COUNT];
    slot_mask_t prev_held;
    cnt_t       tap_frames_cfg = TAP_FRAMES_RESET;

    key_event_t  pending_events [$];
    hold_masks_t expected_masks [$];

    logic in_fire    = 1'b0;
    int   idle_pct   = 0;
    int   send_gap   = 0;
    int   stall_left = 0;
    int   mismatches = 0;

    tap_hold_key_mask_unit i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .key_byte     (key_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .held_mask    (held_mask),
        .pressed_mask (pressed_mask),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] key_of_slot(input int slot);
        case (slot)
            0:       return KEY_A;
            1:       return KEY_B;
            2:       return KEY_X;
            3:       return KEY_Y;
            4:       return KEY_START;
            5:       return KEY_UP;
            6:       return KEY_DOWN;
            7:       return KEY_LEFT;
            8:       return KEY_RIGHT;
            9:       return KEY_Z;
            10:      return KEY_L;
            default: return KEY_R;
        endcase
    endfunction

    function automatic int slot_of_key(input logic [7:0] code);
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            if (key_of_slot(s) == code)
                return s;
        end
        return -1;
    endfunction

    // Advances the timer model by one accepted item; a tick queues its masks.
    function automatic void advance_timers(input logic kind, input logic [7:0] code);
        int          slot;
        hold_masks_t masks;
        if (kind == MODE_KEY)
        begin
            slot = slot_of_key(code);
            if (slot >= 0)
                countdown[slot] = tap_frames_cfg;
        end
        else
        begin
            masks.held = '0;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                if (countdown[s] != 0)
                    countdown[s] = countdown[s] - 1'b1;
                masks.held[s] = (countdown[s] != 0);
            end
            masks.pressed = masks.held & ~prev_held;
            prev_held = masks.held;
            expected_masks.push_back(masks);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    endtask

    task automatic push_event(input logic kind, input logic [7:0] code);
        key_event_t ev;
        ev.kind = kind;
        ev.code = code;
        pending_events.push_back(ev);
    endtask

    // Mostly valid keys and ticks; a share of arbitrary bytes, ignored unless one is a key.
    task automatic queue_random(input int count, input int tick_pct);
        int roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < tick_pct)
                push_event(MODE_TICK, 8'($urandom_range(0, 255)));
            else if (roll < tick_pct + 12)
                push_event(MODE_KEY, 8'($urandom_range(0, 255)));
            else
                push_event(MODE_KEY, key_of_slot($urandom_range(0, SLOT_COUNT - 1)));
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_events.size() != 0 || in_valid || expected_masks.size() != 0);
        // Key bytes give no result, so allow the pipeline to empty as well.
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input cnt_t value);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom();
        data[CNT_W-1:0] = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((addr >> 2) == REG_TAP_FRAMES)
            tap_frames_cfg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_tap_frames();
        logic [CFG_DATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'(4 * REG_TAP_FRAMES);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        if (got !== {{(CFG_DATA_W - CNT_W){1'b0}}, tap_frames_cfg})
            report_mismatch("tap_frames readback", got, 32'(tap_frames_cfg));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sender: holds an item until it is taken, then may leave a gap.
    always @(negedge clk)
    begin : drive_items
        key_event_t ev;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_events.size() != 0)
            begin
                ev = pending_events.pop_front();
                in_valid <= 1'b1;
                mode     <= ev.kind;
                key_byte <= ev.code;
                if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
                    send_gap = $urandom_range(1, 18);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in bursts.
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 2)
                stall_left = $urandom_range(1, 18);
        end
    end

    always @(posedge clk)
    begin : watch_ports
        hold_masks_t want;
        in_fire <= in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_masks.size() == 0)
                begin
                    report_mismatch("result with none expected", 32'(held_mask), 32'd0);
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (held_mask !== want.held)
                        report_mismatch("held_mask", 32'(held_mask), 32'(want.held));
                    if (pressed_mask !== want.pressed)
                        report_mismatch("pressed_mask", 32'(pressed_mask),
                                        32'(want.pressed));
                end
            end
            if (in_valid && in_ready)
                advance_timers(mode, key_byte);
        end
    end

    initial
    begin : run_test
        cnt_t setting;
        int   tick_pct;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        prev_held = '0;
        foreach (countdown[s])
            countdown[s] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_tap_frames();

        // Every key, a retrigger while held, unknown bytes, then ticks past release.
        idle_pct = 25;
        push_event(MODE_KEY, KEY_A);
        push_event(MODE_KEY, KEY_B);
        push_event(MODE_TICK, 8'hFF);
        push_event(MODE_KEY, KEY_X);
        push_event(MODE_KEY, KEY_Y);
        push_event(MODE_KEY, KEY_START);
        push_event(MODE_KEY, KEY_UP);
        push_event(MODE_TICK, 8'h00);
        push_event(MODE_KEY, KEY_A);
        push_event(MODE_TICK, KEY_B);
        push_event(MODE_KEY, KEY_DOWN);
        push_event(MODE_KEY, KEY_LEFT);
        push_event(MODE_KEY, KEY_RIGHT);
        push_event(MODE_KEY, KEY_Z);
        push_event(MODE_KEY, KEY_L);
        push_event(MODE_KEY, KEY_R);
        push_event(MODE_KEY, 8'h00);
        push_event(MODE_KEY, 8'hFF);
        push_event(MODE_KEY, 8'h41);
        repeat (6)
            push_event(MODE_TICK, 8'h55);
        wait_drained();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:       setting = 6'd1;
                1:       setting = 6'd63;
                2:       setting = 6'd0;
                3:       setting = 6'd2;
                4:       setting = cnt_t'($urandom_range(3, 62));
                5:       setting = cnt_t'($urandom_range(0, 63));
                default: setting = TAP_FRAMES_RESET;
            endcase
            // An address past the only register must leave tap_frames alone.
            if (phase == 3)
            begin
                apb_write(CFG_ADDR_W'(4 * (REG_TAP_FRAMES + 1)),
                          cnt_t'($urandom_range(0, 63)));
                check_tap_frames();
            end
            apb_write(CFG_ADDR_W'(4 * REG_TAP_FRAMES), setting);
            check_tap_frames();
            tick_pct = (phase == 1) ? 55 : $urandom_range(30, 55);

            // Two halves; the test waits for every result in between.
            for (int half = 0; half < 2; half++)
            begin
                idle_pct = (phase == 6) ? 0 : $urandom_range(0, 2) * 15;
                queue_random(40, tick_pct);
                wait_drained();
            end
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
